[hw/rtl/digital_zoom_crop_window_unit_defines.svh]
// Assertion macros shared by the digital zoom crop window RTL.
`ifndef DIGITAL_ZOOM_CROP_WINDOW_UNIT_DEFINES_SVH
`define DIGITAL_ZOOM_CROP_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define DZC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define DZC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dzc_pkg.sv]
// Types, widths and constants for the digital zoom crop window unit.
package dzc_pkg;

  localparam int REQ_W      = 2;
  localparam int PAN_W      = 8;
  localparam int BND_W      = 16;
  localparam int CRP_W      = 17;
  localparam int ZOOM_W     = 11;
  localparam int POS_W      = 7;
  localparam int SIZE_W     = BND_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_W      = 22;
  localparam int DEN_W      = ZOOM_W;

  // floor(n/100) as (n*RCP_100) >> RCP_SH, exact for every n below 2**NUM_W
  localparam int RCP_W      = 23;
  localparam int RCP_SH     = 29;
  localparam int RCP_FULL_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_100 = 23'd5368710;

  localparam int DIV_STEPS_DEF = 2;

  localparam logic [ZOOM_W-1:0] RST_DEFAULT_ZOOM = 11'd100;
  localparam logic [ZOOM_W-1:0] RST_MEDIUM_ZOOM  = 11'd200;
  localparam logic [ZOOM_W-1:0] RST_MAX_ZOOM     = 11'd400;
  localparam logic [POS_W-1:0]  RST_PAN_STEP     = 7'd10;
  localparam logic [POS_W-1:0]  RST_CENTER       = 7'd50;

  localparam logic [POS_W-1:0]  POS_MAX   = 7'd100;
  localparam logic [POS_W-1:0]  PCT_MUL   = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ZOOM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_ZOOM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZOOM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER       = 3'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE     = 2'd0,
    REQ_ZOOM_IN  = 2'd1,
    REQ_ZOOM_OUT = 2'd2,
    REQ_PAN      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_H = 2'd1,
    SEL_X = 2'd2,
    SEL_Y = 2'd3
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV_W,
    ST_DIV_H,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     update;
    logic     div_start;
    div_sel_t start_sel;
    logic     capture;
    div_sel_t cap_sel;
    logic     out_load;
  } dzc_cmd_t;

  typedef struct packed {
    logic crop_en;
    logic div_done;
    logic out_busy;
  } dzc_stat_t;

endpackage

[hw/rtl/dzc_div.sv]
// Iterative restoring divider, STEPS quotient bits per cycle.
module dzc_div import dzc_pkg::*; #(
  parameter int STEPS = DIV_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CYC   = (NUM_W + STEPS - 1) / STEPS;
  localparam int PAD_W = CYC * STEPS;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [PAD_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    logic [DEN_W:0] t;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < STEPS; i++) begin
      t       = {rem_nxt, quo_nxt[PAD_W-1]};
      quo_nxt = {quo_nxt[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t          = t - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = t[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CYC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= PAD_W'(numer);
      den_r <= denom;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r[NUM_W-1:0];

endmodule

[hw/rtl/dzc_ctrl.sv]
// Sequencer for command update, up to four divisions and result hand-off.
module dzc_ctrl import dzc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dzc_stat_t stat,
  output dzc_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = stat.crop_en ? ST_DIV_W : ST_DONE;
      ST_DIV_W:  if (stat.div_done) state_nxt = ST_DIV_H;
      ST_DIV_H:  if (stat.div_done) state_nxt = ST_DIV_X;
      ST_DIV_X:  if (stat.div_done) state_nxt = ST_DIV_Y;
      ST_DIV_Y:  if (stat.div_done) state_nxt = ST_DONE;
      ST_DONE:   if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:   cmd.load_in = in_valid;
      ST_UPDATE: cmd.update = 1'b1;
      ST_CHECK: begin
        cmd.div_start = stat.crop_en;
        cmd.start_sel = SEL_W;
      end
      ST_DIV_W: begin
        cmd.capture   = stat.div_done;
        cmd.cap_sel   = SEL_W;
        cmd.div_start = stat.div_done;
        cmd.start_sel = SEL_H;
      end
      ST_DIV_H: begin
        cmd.capture   = stat.div_done;
        cmd.cap_sel   = SEL_H;
        cmd.div_start = stat.div_done;
        cmd.start_sel = SEL_X;
      end
      ST_DIV_X: begin
        cmd.capture   = stat.div_done;
        cmd.cap_sel   = SEL_X;
        cmd.div_start = stat.div_done;
        cmd.start_sel = SEL_Y;
      end
      ST_DIV_Y: begin
        cmd.capture = stat.div_done;
        cmd.cap_sel = SEL_Y;
      end
      ST_DONE:   cmd.out_load = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

[hw/rtl/dzc_dp.sv]
// Datapath: config and view state, shared multiplier and divider, results.
module dzc_dp import dzc_pkg::*; #(
  parameter int DIV_STEPS = DIV_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dzc_cmd_t                cmd,
  output dzc_stat_t               stat,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic signed [PAN_W-1:0] in_pan_horizontal,
  input  logic signed [PAN_W-1:0] in_pan_vertical,
  input  logic signed [BND_W-1:0] in_bounds_x,
  input  logic signed [BND_W-1:0] in_bounds_y,
  input  logic signed [BND_W-1:0] in_bounds_width,
  input  logic signed [BND_W-1:0] in_bounds_height,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [CRP_W-1:0] out_crop_x,
  output logic signed [CRP_W-1:0] out_crop_y,
  output logic signed [BND_W-1:0] out_win_width,
  output logic signed [BND_W-1:0] out_win_height,
  output logic [ZOOM_W-1:0]       out_zoom_now,
  output logic [POS_W-1:0]        out_position_x_out,
  output logic [POS_W-1:0]        out_position_y_out
);

  function automatic logic [POS_W-1:0] moved_pos(input logic [POS_W-1:0] pos,
                                                 input logic signed [PAN_W-1:0] steps,
                                                 input logic [POS_W-1:0] step);
    logic signed [PAN_W+POS_W:0]   prod;
    logic signed [PAN_W+POS_W+1:0] p;
    prod = steps * $signed({1'b0, step});
    p    = {prod[PAN_W+POS_W], prod} + $signed({{(PAN_W+2){1'b0}}, pos});
    if (p[PAN_W+POS_W+1]) begin
      return '0;
    end else if (p > $signed({{(PAN_W+2){1'b0}}, POS_MAX})) begin
      return POS_MAX;
    end else begin
      return p[POS_W-1:0];
    end
  endfunction

  // quotient of dim*100/zoom, held to 1..32767
  function automatic logic [SIZE_W-1:0] sat_size(input logic [NUM_W-1:0] q);
    if (q == '0) begin
      return SIZE_W'(1);
    end else if (q[NUM_W-1:SIZE_W] != '0) begin
      return '1;
    end else begin
      return q[SIZE_W-1:0];
    end
  endfunction

  logic [ZOOM_W-1:0] cfg_def_r, cfg_med_r, cfg_max_r;
  logic [POS_W-1:0]  cfg_pan_r, cfg_ctr_r;
  logic [POS_W-1:0]  ctr_val;

  req_t                    req_r;
  logic signed [PAN_W-1:0] ph_r, pv_r;
  logic signed [BND_W-1:0] bx_r, by_r, bw_r, bh_r;

  logic [ZOOM_W-1:0] zoom_r, zoom_nxt, zoom_out_lvl;
  logic [POS_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt;

  logic [SIZE_W-1:0]       ax_r, ay_r;
  logic signed [CRP_W-1:0] res_x_r, res_y_r;
  logic signed [BND_W-1:0] res_w_r, res_h_r;

  logic [SIZE_W-1:0] mult_a;
  logic [POS_W-1:0]  mult_b;
  logic [NUM_W-1:0]  div_numer;
  logic [DEN_W-1:0]  div_denom;
  logic              div_go;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [SIZE_W-1:0] cap_size;
  logic [BND_W-1:0]  avail_w, avail_h;

  logic                  rcp_start;
  logic                  rcp_busy_r;
  logic                  rcp_done_r;
  logic [NUM_W-1:0]      prod_r;
  logic [RCP_FULL_W-1:0] rcp_full;
  logic [SIZE_W-1:0]     rcp_q_r;

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_def_r <= RST_DEFAULT_ZOOM;
      cfg_med_r <= RST_MEDIUM_ZOOM;
      cfg_max_r <= RST_MAX_ZOOM;
      cfg_pan_r <= RST_PAN_STEP;
      cfg_ctr_r <= RST_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_ZOOM: cfg_def_r <= cfg_data[ZOOM_W-1:0];
        CFG_MEDIUM_ZOOM:  cfg_med_r <= cfg_data[ZOOM_W-1:0];
        CFG_MAX_ZOOM:     cfg_max_r <= cfg_data[ZOOM_W-1:0];
        CFG_PAN_STEP:     cfg_pan_r <= cfg_data[POS_W-1:0];
        CFG_CENTER:       cfg_ctr_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign ctr_val = (cfg_ctr_r > POS_MAX) ? POS_MAX : cfg_ctr_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= req_t'(in_req_type);
      ph_r  <= in_pan_horizontal;
      pv_r  <= in_pan_vertical;
      bx_r  <= in_bounds_x;
      by_r  <= in_bounds_y;
      bw_r  <= in_bounds_width;
      bh_r  <= in_bounds_height;
    end
  end

  assign zoom_out_lvl = (zoom_r > cfg_med_r) ? cfg_med_r : cfg_def_r;

  always_comb begin
    zoom_nxt = zoom_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    if (cmd.update) begin
      unique case (req_r)
        REQ_NONE: ;
        REQ_ZOOM_IN: zoom_nxt = (zoom_r < cfg_med_r) ? cfg_med_r : cfg_max_r;
        REQ_ZOOM_OUT: begin
          zoom_nxt = zoom_out_lvl;
          if (zoom_out_lvl == cfg_def_r) begin
            vx_nxt = ctr_val;
            vy_nxt = ctr_val;
          end
        end
        REQ_PAN: begin
          if (zoom_r != cfg_def_r) begin
            vx_nxt = moved_pos(vx_r, ph_r, cfg_pan_r);
            vy_nxt = moved_pos(vy_r, pv_r, cfg_pan_r);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r <= RST_DEFAULT_ZOOM;
      vx_r   <= RST_CENTER;
      vy_r   <= RST_CENTER;
    end else begin
      zoom_r <= zoom_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
    end
  end

  assign stat.crop_en = (zoom_r != cfg_def_r) && (zoom_r != '0) &&
                        !bw_r[BND_W-1] && (bw_r != '0) &&
                        !bh_r[BND_W-1] && (bh_r != '0);

  // one multiplier: size*100 goes to the divider, travel*pos to the /100 scaler
  always_comb begin
    case (cmd.start_sel)
      SEL_W:   mult_a = bw_r[SIZE_W-1:0];
      SEL_H:   mult_a = bh_r[SIZE_W-1:0];
      SEL_X:   mult_a = ax_r;
      default: mult_a = ay_r;
    endcase
    case (cmd.start_sel) inside
      SEL_W, SEL_H: mult_b = PCT_MUL;
      SEL_X:        mult_b = vx_r;
      default:      mult_b = vy_r;
    endcase
  end

  assign div_numer = NUM_W'(mult_a) * NUM_W'(mult_b);
  assign div_denom = zoom_r;

  assign rcp_start = cmd.div_start &&
                     ((cmd.start_sel == SEL_X) || (cmd.start_sel == SEL_Y));
  assign div_go    = cmd.div_start && !rcp_start;

  dzc_div #(
    .STEPS (DIV_STEPS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  // offset over 100: product registered, then reciprocal multiply registered
  assign rcp_full = RCP_FULL_W'(prod_r) * RCP_FULL_W'(RCP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcp_busy_r <= 1'b0;
      rcp_done_r <= 1'b0;
    end else begin
      rcp_busy_r <= rcp_start;
      rcp_done_r <= rcp_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rcp_start) begin
      prod_r <= div_numer;
    end
    if (rcp_busy_r) begin
      rcp_q_r <= rcp_full[RCP_SH +: SIZE_W];
    end
  end

  assign stat.div_done = div_done || rcp_done_r;

  assign cap_size = sat_size(div_quot);
  assign avail_w  = {1'b0, bw_r[SIZE_W-1:0]} - {1'b0, cap_size};
  assign avail_h  = {1'b0, bh_r[SIZE_W-1:0]} - {1'b0, cap_size};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_x_r <= {in_bounds_x[BND_W-1], in_bounds_x};
      res_y_r <= {in_bounds_y[BND_W-1], in_bounds_y};
      res_w_r <= in_bounds_width;
      res_h_r <= in_bounds_height;
    end else if (cmd.capture) begin
      // offset quotient never exceeds the travel, so its low bits suffice
      case (cmd.cap_sel)
        SEL_W: begin
          res_w_r <= {1'b0, cap_size};
          ax_r    <= avail_w[BND_W-1] ? '0 : avail_w[SIZE_W-1:0];
        end
        SEL_H: begin
          res_h_r <= {1'b0, cap_size};
          ay_r    <= avail_h[BND_W-1] ? '0 : avail_h[SIZE_W-1:0];
        end
        SEL_X:   res_x_r <= {bx_r[BND_W-1], bx_r} + {2'b00, rcp_q_r};
        default: res_y_r <= {by_r[BND_W-1], by_r} + {2'b00, rcp_q_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_crop_x         <= res_x_r;
      out_crop_y         <= res_y_r;
      out_win_width      <= res_w_r;
      out_win_height     <= res_h_r;
      out_zoom_now       <= zoom_r;
      out_position_x_out <= vx_r;
      out_position_y_out <= vy_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_busy = out_valid_r && out_stall;

endmodule

[hw/rtl/digital_zoom_crop_window_unit.sv]
// Top level of the digital zoom crop window unit: sequencer plus datapath.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  command and source rectangle
//   out_     output     out_valid/out_stall  crop window, zoom and view position
//   cfg_     input      cfg_we               one register write, no read-back
//
// One item at a time: a cropped item takes two runs of the shared divider and
// two scalings by 100, a pass-through item neither. The result is in the
// output register before the next item is accepted; a waiting result only
// holds the hand-off of the next one. Synchronous active-low reset restores
// the register defaults, zoom 100 and view position 50 on both axes.
`include "digital_zoom_crop_window_unit_defines.svh"

module digital_zoom_crop_window_unit import dzc_pkg::*; #(
  parameter int DIV_STEPS = DIV_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic signed [PAN_W-1:0] in_pan_horizontal,
  input  logic signed [PAN_W-1:0] in_pan_vertical,
  input  logic signed [BND_W-1:0] in_bounds_x,
  input  logic signed [BND_W-1:0] in_bounds_y,
  input  logic signed [BND_W-1:0] in_bounds_width,
  input  logic signed [BND_W-1:0] in_bounds_height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [CRP_W-1:0] out_crop_x,
  output logic signed [CRP_W-1:0] out_crop_y,
  output logic signed [BND_W-1:0] out_win_width,
  output logic signed [BND_W-1:0] out_win_height,
  output logic [ZOOM_W-1:0]       out_zoom_now,
  output logic [POS_W-1:0]        out_position_x_out,
  output logic [POS_W-1:0]        out_position_y_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  dzc_cmd_t  cmd;
  dzc_stat_t stat;
  logic      view_ok;

  dzc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dzc_dp #(
    .DIV_STEPS (DIV_STEPS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_pan_horizontal  (in_pan_horizontal),
    .in_pan_vertical    (in_pan_vertical),
    .in_bounds_x        (in_bounds_x),
    .in_bounds_y        (in_bounds_y),
    .in_bounds_width    (in_bounds_width),
    .in_bounds_height   (in_bounds_height),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_crop_x         (out_crop_x),
    .out_crop_y         (out_crop_y),
    .out_win_width      (out_win_width),
    .out_win_height     (out_win_height),
    .out_zoom_now       (out_zoom_now),
    .out_position_x_out (out_position_x_out),
    .out_position_y_out (out_position_y_out)
  );

  assign view_ok = (out_position_x_out <= POS_MAX) && (out_position_y_out <= POS_MAX);

  `DZC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no work after accept")
  `DZC_ASSERT_IMPL(a_quotient_taken, stat.div_done, cmd.capture, "divider result dropped")
  `DZC_ASSERT_IMPL(a_position_range, out_valid, view_ok, "view position above 100")

endmodule

[tb/tb_digital_zoom_crop_window_unit.sv]
// Self-checking testbench for the digital zoom crop window unit.
import dzc_pkg::*;

typedef struct {
  req_t              req;
  logic signed [7:0]  ph;
  logic signed [7:0]  pv;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  logic signed [15:0] bw;
  logic signed [15:0] bh;
} crop_req_t;

typedef struct {
  logic [16:0] x;
  logic [16:0] y;
  logic [15:0] w;
  logic [15:0] h;
  logic [10:0] zoom;
  logic [6:0]  px;
  logic [6:0]  py;
} crop_win_t;

class crop_scoreboard;
  logic [10:0] zoom_dflt;
  logic [10:0] zoom_mid;
  logic [10:0] zoom_top;
  logic [6:0]  step_pct;
  logic [6:0]  center_pct;
  logic [10:0] zoom_lvl;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  crop_win_t   expected_windows[$];
  int          errors;
  int          checked;

  function new();
    zoom_dflt  = RST_DEFAULT_ZOOM;
    zoom_mid   = RST_MEDIUM_ZOOM;
    zoom_top   = RST_MAX_ZOOM;
    step_pct   = RST_PAN_STEP;
    center_pct = RST_CENTER;
    zoom_lvl   = zoom_dflt;
    pos_x      = center_clamped();
    pos_y      = center_clamped();
    errors     = 0;
    checked    = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] val);
    case (idx)
      CFG_DEFAULT_ZOOM: zoom_dflt = val;
      CFG_MEDIUM_ZOOM:  zoom_mid = val;
      CFG_MAX_ZOOM:     zoom_top = val;
      CFG_PAN_STEP:     step_pct = val[6:0];
      CFG_CENTER:       center_pct = val[6:0];
      default: ;
    endcase
  endfunction

  function logic [6:0] center_clamped();
    return (center_pct > 7'd100) ? 7'd100 : center_pct;
  endfunction

  function logic [6:0] pan_move(logic [6:0] pos, logic signed [7:0] steps);
    longint p;
    p = longint'(pos) + longint'(steps) * longint'(step_pct);
    if (p < 0) p = 0;
    if (p > 100) p = 100;
    return p[6:0];
  endfunction

  function longint scale_dim(longint dim, logic [10:0] z);
    longint s;
    s = dim * 100 / longint'(z);
    if (s < 1) s = 1;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  // Apply the command, then work out the crop window it yields.
  function void note_request(crop_req_t r);
    crop_win_t w;
    longint cx, cy, cw, ch, ax, ay;
    case (r.req)
      REQ_ZOOM_IN: zoom_lvl = (zoom_lvl < zoom_mid) ? zoom_mid : zoom_top;
      REQ_ZOOM_OUT: begin
        zoom_lvl = (zoom_lvl > zoom_mid) ? zoom_mid : zoom_dflt;
        if (zoom_lvl == zoom_dflt) begin
          pos_x = center_clamped();
          pos_y = center_clamped();
        end
      end
      REQ_PAN: begin
        if (zoom_lvl != zoom_dflt) begin
          pos_x = pan_move(pos_x, r.ph);
          pos_y = pan_move(pos_y, r.pv);
        end
      end
      default: ;
    endcase
    cx = longint'(r.bx);
    cy = longint'(r.by);
    cw = longint'(r.bw);
    ch = longint'(r.bh);
    if (zoom_lvl != zoom_dflt && zoom_lvl != 0 && r.bw > 0 && r.bh > 0) begin
      cw = scale_dim(longint'(r.bw), zoom_lvl);
      ch = scale_dim(longint'(r.bh), zoom_lvl);
      ax = longint'(r.bw) - cw;
      ay = longint'(r.bh) - ch;
      if (ax < 0) ax = 0;
      if (ay < 0) ay = 0;
      cx = longint'(r.bx) + ax * longint'(pos_x) / 100;
      cy = longint'(r.by) + ay * longint'(pos_y) / 100;
    end
    w.x    = cx[16:0];
    w.y    = cy[16:0];
    w.w    = cw[15:0];
    w.h    = ch[15:0];
    w.zoom = zoom_lvl;
    w.px   = pos_x;
    w.py   = pos_y;
    expected_windows.push_back(w);
  endfunction

  function void check_field(string nm, logic [16:0] exp_v, logic [16:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, nm, exp_v, act_v);
    end
  endfunction

  function void check_window(crop_win_t got);
    crop_win_t e;
    if (expected_windows.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none got x=%0h y=%0h w=%0h h=%0h",
               $time, got.x, got.y, got.w, got.h);
      return;
    end
    e = expected_windows.pop_front();
    checked++;
    check_field("crop_x", e.x, got.x);
    check_field("crop_y", e.y, got.y);
    check_field("win_width", {1'b0, e.w}, {1'b0, got.w});
    check_field("win_height", {1'b0, e.h}, {1'b0, got.h});
    check_field("zoom_now", {6'b0, e.zoom}, {6'b0, got.zoom});
    check_field("position_x", {10'b0, e.px}, {10'b0, got.px});
    check_field("position_y", {10'b0, e.py}, {10'b0, got.py});
  endfunction
endclass

module tb_digital_zoom_crop_window_unit;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 55;
  localparam int NUM_PHASES  = 10;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        in_req_type = REQ_NONE;
  logic signed [PAN_W-1:0] in_pan_horizontal = '0;
  logic signed [PAN_W-1:0] in_pan_vertical = '0;
  logic signed [BND_W-1:0] in_bounds_x = '0;
  logic signed [BND_W-1:0] in_bounds_y = '0;
  logic signed [BND_W-1:0] in_bounds_width = '0;
  logic signed [BND_W-1:0] in_bounds_height = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CRP_W-1:0] out_crop_x;
  logic signed [CRP_W-1:0] out_crop_y;
  logic signed [BND_W-1:0] out_win_width;
  logic signed [BND_W-1:0] out_win_height;
  logic [ZOOM_W-1:0]       out_zoom_now;
  logic [POS_W-1:0]        out_position_x_out;
  logic [POS_W-1:0]        out_position_y_out;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_DEFAULT_ZOOM;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  crop_scoreboard sb = new();
  int send_idle = 12;
  int recv_idle = 85;
  int cycles = 0;
  int sent = 0;
  int settings_run = 0;

  // zoom default, medium, max, pan step, center
  int cfg_table[NUM_PHASES][5] = '{
    '{100, 200, 400, 10, 50},
    '{100, 1600, 1600, 100, 100},
    '{100, 101, 1600, 1, 0},
    '{100, 50, 25, 3, 120},
    '{100, 0, 0, 127, 50},
    '{0, 0, 0, 0, 0},
    '{2047, 2047, 2047, 64, 127},
    '{300, 200, 100, 25, 30},
    '{120, 140, 160, 2, 75},
    '{0, 0, 0, 0, 0}
  };

  digital_zoom_crop_window_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_pan_horizontal(in_pan_horizontal), .in_pan_vertical(in_pan_vertical),
    .in_bounds_x(in_bounds_x), .in_bounds_y(in_bounds_y),
    .in_bounds_width(in_bounds_width), .in_bounds_height(in_bounds_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_crop_x(out_crop_x), .out_crop_y(out_crop_y),
    .out_win_width(out_win_width), .out_win_height(out_win_height),
    .out_zoom_now(out_zoom_now),
    .out_position_x_out(out_position_x_out), .out_position_y_out(out_position_y_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows still due", cycles,
               sb.expected_windows.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: values read here are the ones present before this edge.
  always @(posedge clk) begin
    crop_win_t w;
    if (rst_n && out_valid && !out_stall) begin
      w.x    = out_crop_x;
      w.y    = out_crop_y;
      w.w    = out_win_width;
      w.h    = out_win_height;
      w.zoom = out_zoom_now;
      w.px   = out_position_x_out;
      w.py   = out_position_y_out;
      sb.check_window(w);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  function automatic crop_req_t mk(req_t q, int ph, int pv, int bx, int by, int bw, int bh);
    crop_req_t r;
    r.req = q;
    r.ph  = 8'(ph);
    r.pv  = 8'(pv);
    r.bx  = 16'(bx);
    r.by  = 16'(by);
    r.bw  = 16'(bw);
    r.bh  = 16'(bh);
    return r;
  endfunction

  function automatic logic signed [15:0] random_dim();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4));
      2: return 16'(32767 - $urandom_range(0, 3));
      3: return -16'($urandom_range(1, 32768));
      default: return 16'($urandom_range(16, 4096));
    endcase
  endfunction

  function automatic crop_req_t random_request();
    crop_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) r.req = REQ_NONE;
    else if (pick < 45) r.req = REQ_ZOOM_IN;
    else if (pick < 65) r.req = REQ_ZOOM_OUT;
    else r.req = REQ_PAN;
    if ($urandom_range(0, 3) == 0) begin
      r.ph = 8'($urandom);
      r.pv = 8'($urandom);
    end else begin
      r.ph = 8'($urandom_range(0, 6)) - 8'd3;
      r.pv = 8'($urandom_range(0, 6)) - 8'd3;
    end
    if ($urandom_range(0, 1) == 0) begin
      r.bx = 16'($urandom);
      r.by = 16'($urandom);
    end else begin
      r.bx = 16'($urandom_range(0, 2000));
      r.by = 16'($urandom_range(0, 2000));
    end
    r.bw = random_dim();
    r.bh = random_dim();
    return r;
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic drive_request(input crop_req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= r.req;
    in_pan_horizontal <= r.ph;
    in_pan_vertical   <= r.pv;
    in_bounds_x       <= r.bx;
    in_bounds_y       <= r.by;
    in_bounds_width   <= r.bw;
    in_bounds_height  <= r.bh;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_windows.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    crop_req_t directed[$];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: pass-through, ignored pan, clamps, max zoom, recenter.
    directed.push_back(mk(REQ_NONE, 0, 0, 0, 0, 640, 480));
    directed.push_back(mk(REQ_PAN, 127, -128, 10, 20, 640, 480));
    directed.push_back(mk(REQ_ZOOM_IN, 0, 0, -32768, -32768, 32767, 32767));
    directed.push_back(mk(REQ_PAN, 1, -1, 100, 50, 640, 480));
    directed.push_back(mk(REQ_PAN, 127, 127, 0, 0, 1920, 1080));
    directed.push_back(mk(REQ_PAN, -128, -128, 0, 0, 1920, 1080));
    directed.push_back(mk(REQ_PAN, -1, 2, 32767, 32767, 32767, 32767));
    directed.push_back(mk(REQ_ZOOM_IN, 0, 0, 0, 0, 1, 1));
    directed.push_back(mk(REQ_ZOOM_IN, 0, 0, 0, 0, 3, 2));
    directed.push_back(mk(REQ_NONE, 0, 0, 5, 5, 0, 100));
    directed.push_back(mk(REQ_NONE, 0, 0, 5, 5, 100, -1));
    directed.push_back(mk(REQ_NONE, 0, 0, -1, -1, -32768, -32768));
    directed.push_back(mk(REQ_PAN, 3, -3, -32768, 0, 32767, 1));
    directed.push_back(mk(REQ_ZOOM_OUT, 0, 0, 0, 0, 800, 600));
    directed.push_back(mk(REQ_PAN, -2, 5, 0, 0, 800, 600));
    directed.push_back(mk(REQ_ZOOM_OUT, 0, 0, 0, 0, 800, 600));
    directed.push_back(mk(REQ_ZOOM_OUT, 0, 0, 7, 7, 800, 600));
    directed.push_back(mk(REQ_NONE, -1, -1, 32767, -32768, 2, 2));
    directed.push_back(mk(REQ_ZOOM_IN, -128, 127, 0, 0, 32767, 32767));
    directed.push_back(mk(REQ_PAN, 127, -128, 0, 0, 32767, 32767));
    directed.push_back(mk(REQ_ZOOM_OUT, 0, 0, 0, 0, 1000, 1000));
    foreach (directed[i]) drive_request(directed[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle = 12;
        recv_idle = 85;
      end else if (p < 7) begin
        send_idle = 85;
        recv_idle = 12;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == NUM_PHASES - 1) begin
        // Fully random setting, pan step and center above their range included.
        write_reg(CFG_DEFAULT_ZOOM, 11'($urandom));
        write_reg(CFG_MEDIUM_ZOOM, 11'($urandom));
        write_reg(CFG_MAX_ZOOM, 11'($urandom));
        write_reg(CFG_PAN_STEP, 11'($urandom));
        write_reg(CFG_CENTER, 11'($urandom));
        write_reg(CFG_CENTER + 3'($urandom_range(1, 3)), 11'($urandom));
      end else begin
        write_reg(CFG_DEFAULT_ZOOM, 11'(cfg_table[p][0]));
        write_reg(CFG_MEDIUM_ZOOM, 11'(cfg_table[p][1]));
        write_reg(CFG_MAX_ZOOM, 11'(cfg_table[p][2]));
        write_reg(CFG_PAN_STEP, 11'(cfg_table[p][3]));
        write_reg(CFG_CENTER, 11'(cfg_table[p][4]));
      end
      cfg_we <= 1'b0;
      settings_run++;
      for (int i = 0; i < PHASE_ITEMS; i++) drive_request(random_request());
      drain();
    end

    $display("%0d requests driven under %0d register settings plus reset defaults",
             sent, settings_run);
    $display("%0d crop windows checked, %0d field mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
